// File: hw/rtl/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg: shared types and constants of the gap-buffer engine
// Store geometry, command codes, sequencer states and the structs that pass
// between the controller, the byte mover and the store RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package gbe_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PTR_W       = $clog2(STORE_DEPTH + 1);

    // Fixed field widths of the command and result ports
    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 13;

    // Width that holds both a requested move count and a pointer
    localparam int CMP_W = (COUNT_W > PTR_W) ? COUNT_W : PTR_W;

    localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(STORE_DEPTH);

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR     = 3'd0,
        OP_INSERT    = 3'd1,
        OP_DELETE    = 3'd2,
        OP_BACKSPACE = 3'd3,
        OP_LEFT      = 3'd4,
        OP_RIGHT     = 3'd5,
        OP_PEEK      = 3'd6
    } t_opcode;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_MOVE   = 5'b00100,
        ST_FETCH  = 5'b01000,
        ST_RESULT = 5'b10000
    } t_state;

    // Block copy request from the controller to the mover
    typedef struct packed {
        logic              go;
        logic              down;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [PTR_W-1:0]  count;
    } t_move_req;

    typedef struct packed {
        logic busy;
    } t_move_sts;

    // One read and one write access to the store RAM
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
    } t_ram_port;

endpackage

`default_nettype wire

// File: hw/rtl/gbe_ram.sv
// ----------------------------------------------------------------------------
// gbe_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gbe_mover.sv
// ----------------------------------------------------------------------------
// gbe_mover: byte-by-byte block copy across the gap
// Read one source byte a cycle and write it in the following cycle; step both
// addresses up or down through one shared step value.
// ----------------------------------------------------------------------------
`default_nettype none

module gbe_mover
    import gbe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_move_req         i_req,
    input  wire logic [BYTE_W-1:0] i_rd_data,
    output t_move_sts              o_sts,
    output t_ram_port              o_ram
);

    logic [ADDR_W-1:0] r_src;
    logic [ADDR_W-1:0] r_dst;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [PTR_W-1:0]  r_left;
    logic              r_wr_pend;
    logic              r_down;
    logic [ADDR_W-1:0] step;
    logic              reading;

    // All ones steps down by one
    assign step    = r_down ? {ADDR_W{1'b1}} : ADDR_W'(1);
    assign reading = (r_left != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_wr_pend <= 1'b0;
        end else if (i_req.go) begin
            r_src     <= i_req.src;
            r_dst     <= i_req.dst;
            r_down    <= i_req.down;
            r_left    <= i_req.count;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= reading;
            if (reading) begin
                r_src     <= r_src + step;
                r_dst     <= r_dst + step;
                r_wr_addr <= r_dst;
                r_left    <= r_left - PTR_W'(1);
            end
        end
    end

    always_comb begin
        o_ram.re    = reading;
        o_ram.raddr = r_src;
        o_ram.we    = r_wr_pend;
        o_ram.waddr = r_wr_addr;
        o_ram.wdata = i_rd_data;
        o_sts.busy  = reading | r_wr_pend;
    end

endmodule

`default_nettype wire

// File: hw/rtl/gap_buffer_engine.sv
// ----------------------------------------------------------------------------
// gap_buffer_engine: gap-buffer text store
// Command-driven byte store with a movable gap at the cursor.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge with start high and busy low; busy then
// stays high until the result has been shown. Each result is on the o_ ports
// for exactly one cycle, marked by o_strobe, and cannot be held off: capture
// it in that cycle. Clear, insert, delete, backspace, refused commands and
// the unused opcode pass through accept, decode and result; peek and a
// cursor move of zero bytes add one RAM read of the byte after the gap. A
// cursor move of n > 0 bytes also waits while the mover copies one byte a
// cycle through the single store RAM read and write port, drains its last
// write and is seen to go idle, then reads the new byte after the gap.
// busy drops in the cycle after the strobe, so a new command can be taken
// in the cycle after each result. There is no clearing pass after reset:
// store contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_engine
    import gbe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [BYTE_W-1:0]   i_data_byte,
    input  wire logic [COUNT_W-1:0]  i_move_count,
    output logic                     o_strobe,
    output logic                     o_ok,
    output logic [BYTE_W-1:0]        o_byte_after_gap,
    output logic [COUNT_W-1:0]       o_used_count,
    output logic [COUNT_W-1:0]       o_free_count
);

    // Sequencer and command registers
    t_state               r_state, n_state;
    t_opcode              r_op;
    logic [BYTE_W-1:0]    r_data;
    logic [COUNT_W-1:0]   r_count;

    // Gap pointers: prefix is [0, gap_start), suffix is [gap_end, depth)
    logic [PTR_W-1:0]     r_gap_start, n_gap_start;
    logic [PTR_W-1:0]     r_gap_end, n_gap_end;

    // Result fields
    logic                 r_ok, n_ok;
    logic                 r_byte_sel, n_byte_sel;

    // Decode arithmetic
    logic [PTR_W-1:0]     have;
    logic [CMP_W-1:0]     cnt_ext;
    logic [CMP_W-1:0]     have_ext;
    logic [PTR_W-1:0]     move_n;
    logic                 prefix_empty;
    logic                 suffix_empty;

    // Store access
    t_move_req            move_req;
    t_move_sts            move_sts;
    t_ram_port            mover_ram;
    t_ram_port            ctrl_ram;
    t_ram_port            ram;
    logic [BYTE_W-1:0]    rd_data;

    assign prefix_empty = (r_gap_start == '0);
    assign suffix_empty = (r_gap_end == DEPTH_PTR);

    // Clamp the requested distance to what lies on that side of the gap
    assign have     = (r_op == OP_LEFT) ? r_gap_start : (DEPTH_PTR - r_gap_end);
    assign cnt_ext  = CMP_W'(r_count);
    assign have_ext = CMP_W'(have);
    assign move_n   = (cnt_ext < have_ext) ? PTR_W'(cnt_ext) : have;

    always_comb begin
        n_state     = r_state;
        n_gap_start = r_gap_start;
        n_gap_end   = r_gap_end;
        n_ok        = r_ok;
        n_byte_sel  = r_byte_sel;

        move_req       = '0;
        ctrl_ram       = '0;
        ctrl_ram.waddr = r_gap_start[ADDR_W-1:0];
        ctrl_ram.wdata = r_data;
        ctrl_ram.raddr = r_gap_end[ADDR_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECODE;
                end
            end

            ST_DECODE: begin
                n_ok       = 1'b0;
                n_byte_sel = 1'b0;
                n_state    = ST_RESULT;
                case (r_op)
                    OP_CLEAR: begin
                        n_gap_start = '0;
                        n_gap_end   = DEPTH_PTR;
                        n_ok        = 1'b1;
                    end
                    OP_INSERT: begin
                        // Refuse when the gap is closed
                        if (r_gap_start != r_gap_end) begin
                            ctrl_ram.we = 1'b1;
                            n_gap_start = r_gap_start + PTR_W'(1);
                            n_ok        = 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        if (!suffix_empty) begin
                            n_gap_end = r_gap_end + PTR_W'(1);
                            n_ok      = 1'b1;
                        end
                    end
                    OP_BACKSPACE: begin
                        if (!prefix_empty) begin
                            n_gap_start = r_gap_start - PTR_W'(1);
                            n_ok        = 1'b1;
                        end
                    end
                    OP_LEFT: begin
                        // Copy the prefix tail to below gap_end, top down
                        if (!prefix_empty) begin
                            n_ok           = 1'b1;
                            move_req.go    = (move_n != '0);
                            move_req.down  = 1'b1;
                            move_req.src   = ADDR_W'(r_gap_start - PTR_W'(1));
                            move_req.dst   = ADDR_W'(r_gap_end - PTR_W'(1));
                            move_req.count = move_n;
                            n_gap_start    = r_gap_start - move_n;
                            n_gap_end      = r_gap_end - move_n;
                            n_state        = (move_n != '0) ? ST_MOVE : ST_FETCH;
                        end
                    end
                    OP_RIGHT: begin
                        // Copy the suffix head to gap_start, bottom up
                        if (!suffix_empty) begin
                            n_ok           = 1'b1;
                            move_req.go    = (move_n != '0);
                            move_req.down  = 1'b0;
                            move_req.src   = r_gap_end[ADDR_W-1:0];
                            move_req.dst   = r_gap_start[ADDR_W-1:0];
                            move_req.count = move_n;
                            n_gap_start    = r_gap_start + move_n;
                            n_gap_end      = r_gap_end + move_n;
                            n_state        = (move_n != '0) ? ST_MOVE : ST_FETCH;
                        end
                    end
                    OP_PEEK: begin
                        if (!suffix_empty) begin
                            n_ok    = 1'b1;
                            n_state = ST_FETCH;
                        end
                    end
                    default: begin
                        // Unused opcode: report counts, change nothing
                        n_ok = 1'b0;
                    end
                endcase
            end

            ST_MOVE: begin
                // Hold until the last copied byte is written
                if (!move_sts.busy) begin
                    n_state = ST_FETCH;
                end
            end

            ST_FETCH: begin
                // Read the byte after the gap; zero when the suffix is empty
                ctrl_ram.re = !suffix_empty;
                n_byte_sel  = !suffix_empty;
                n_state     = ST_RESULT;
            end

            ST_RESULT: begin
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gap_start <= '0;
            r_gap_end   <= DEPTH_PTR;
            r_ok        <= 1'b0;
            r_byte_sel  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gap_start <= n_gap_start;
            r_gap_end   <= n_gap_end;
            r_ok        <= n_ok;
            r_byte_sel  <= n_byte_sel;
        end
    end

    // Capture the command of each accepted transaction
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= t_opcode'(i_opcode);
            r_data  <= i_data_byte;
            r_count <= i_move_count;
        end
    end

    // The mover owns the store port while a block copy runs
    assign ram = (r_state == ST_MOVE) ? mover_ram : ctrl_ram;

    gbe_mover u_mover (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (move_req),
        .i_rd_data (rd_data),
        .o_sts     (move_sts),
        .o_ram     (mover_ram)
    );

    gbe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (rd_data)
    );

    // Result outputs
    assign busy             = (r_state != ST_IDLE);
    assign o_strobe         = (r_state == ST_RESULT);
    assign o_ok             = r_ok;
    assign o_byte_after_gap = r_byte_sel ? rd_data : '0;
    assign o_used_count     = COUNT_W'(r_gap_start + (DEPTH_PTR - r_gap_end));
    assign o_free_count     = COUNT_W'(r_gap_end - r_gap_start);

endmodule

`default_nettype wire
